/* hdl/b64_pkg.sv */
package b64_pkg;

  localparam int unsigned SLOTS  = 4;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef logic [2:0] slot_cnt_t;

  // one accepted request turns into at most one job of up to four results
  typedef struct packed {
    logic [SLOTS-1:0][7:0] data;
    logic                  bad;
    slot_cnt_t             cnt;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h2F;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end
    return c;
  endfunction

  // {ok, value}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

/* hdl/b64_front.sv */
module b64_front
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       fire,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       push,
  output job_t       job
);

  logic        direction;
  logic [23:0] group_buffer, group_buffer_next;
  logic [1:0]  group_count, group_count_next;
  logic        pad_seen, pad_seen_next;

  logic [1:0]  epos;
  logic [2:0]  pos, pos1;
  logic [23:0] merged;
  logic [6:0]  cv;
  logic        clr;

  always_comb begin
    job               = '0;
    clr               = 1'b0;
    group_buffer_next = group_buffer;
    group_count_next  = group_count;
    pad_seen_next     = pad_seen;
    pos               = {1'b0, group_count};
    pos1              = pos + 3'd1;
    epos              = (group_count == 2'd3) ? 2'd2 : group_count;
    cv                = dec_char(in_data);
    merged            = group_buffer;

    if (direction == DIR_ENCODE) begin
      unique case (epos)
        2'd0:    merged = group_buffer | {in_data, 16'h0000};
        2'd1:    merged = group_buffer | {8'h00, in_data, 8'h00};
        default: merged = group_buffer | {16'h0000, in_data};
      endcase
      if (epos != 2'd2 && !in_last) begin
        group_buffer_next = merged;
        group_count_next  = epos + 2'd1;
      end else begin
        job.cnt = 3'd4;
        for (int i = 0; i < SLOTS; i++) begin
          if (3'(i) <= {1'b0, epos} + 3'd1) begin
            job.data[i] = enc_char(merged[23-6*i -: 6]);
          end else begin
            job.data[i] = PAD_CHAR;
          end
        end
        clr = 1'b1;
      end
    end else begin
      if (pad_seen) begin
        // swallow the rest of a padded group
        if (pos1 == 3'd4 || in_last) begin
          clr = 1'b1;
        end else begin
          group_count_next = pos1[1:0];
        end
      end else if (in_data == PAD_CHAR) begin
        if (pos >= 3'd2) begin
          job.cnt     = pos - 3'd1;
          job.data[0] = group_buffer[23:16];
          job.data[1] = group_buffer[15:8];
        end
        if (pos1 == 3'd4 || in_last) begin
          clr = 1'b1;
        end else begin
          group_count_next = pos1[1:0];
          pad_seen_next    = 1'b1;
        end
      end else if (!cv[6]) begin
        job.bad     = 1'b1;
        job.cnt     = 3'd1;
        job.data[0] = 8'h00;
        job.data[1] = group_buffer[23:16];
        job.data[2] = group_buffer[15:8];
        if (in_last) begin
          // tail flush follows the error result
          if (pos >= 3'd2) begin
            job.cnt = pos;
          end
          clr = 1'b1;
        end
      end else begin
        unique case (group_count)
          2'd0:    merged = group_buffer | {cv[5:0], 18'h00000};
          2'd1:    merged = group_buffer | {6'h00, cv[5:0], 12'h000};
          2'd2:    merged = group_buffer | {12'h000, cv[5:0], 6'h00};
          default: merged = group_buffer | {18'h00000, cv[5:0]};
        endcase
        job.data[0] = merged[23:16];
        job.data[1] = merged[15:8];
        job.data[2] = merged[7:0];
        if (pos1 == 3'd4) begin
          job.cnt = 3'd3;
          clr     = 1'b1;
        end else if (in_last) begin
          if (pos1 >= 3'd2) begin
            job.cnt = pos;
          end
          clr = 1'b1;
        end else begin
          group_buffer_next = merged;
          group_count_next  = pos1[1:0];
        end
      end
    end

    if (clr) begin
      group_buffer_next = '0;
      group_count_next  = '0;
      pad_seen_next     = 1'b0;
    end
  end

  assign push = fire && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_ENCODE;
      group_buffer <= '0;
      group_count  <= '0;
      pad_seen     <= 1'b0;
    end else if (cfg_write_en) begin
      direction    <= cfg_write_data;
      group_buffer <= '0;
      group_count  <= '0;
      pad_seen     <= 1'b0;
    end else if (fire) begin
      group_buffer <= group_buffer_next;
      group_count  <= group_count_next;
      pad_seen     <= pad_seen_next;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_ENCODE) |-> (group_count != 2'd3) && !pad_seen)
    else $error("encode group state out of range");
  assert property (@(posedge clk) disable iff (rst)
    push |-> (job.cnt <= 3'd4))
    else $error("job larger than four results");
  assert property (@(posedge clk) disable iff (rst)
    (push && job.bad) |-> (direction == DIR_DECODE) && (job.data[0] == 8'h00))
    else $error("bad character job malformed");
`endif

endmodule

/* hdl/b64_queue.sv */
module b64_queue
  import b64_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t             entries [QDEPTH];
  logic [QPTRW-1:0] wr_ptr, rd_ptr;
  logic [QCNTW-1:0] count;

  assign full    = (count == QCNTW'(QDEPTH));
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTRW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTRW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNTW'(1);
        2'b01:   count <= count - QCNTW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    count <= QCNTW'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid))
    else $error("pop from empty queue");
`endif

endmodule

/* hdl/b64_back.sv */
module b64_back
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       bad_char
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       adv, fin;

  assign adv = cur_valid && (!out_valid || !out_stall);
  assign fin = adv && ({1'b0, idx} == cur.cnt - 3'd1);
  assign pop = q_valid && (!cur_valid || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fin) begin
      cur_valid <= 1'b0;
    end else if (adv) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the presented result while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= cur.data[idx];
      out_last <= fin;
      bad_char <= cur.bad && (idx == 2'd0);
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, idx} < cur.cnt))
    else $error("slot index past job length");
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != 3'd0) && (cur.cnt <= 3'd4))
    else $error("empty or oversized job in flight");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_char) |-> (out_data == 8'h00))
    else $error("error result carries data");
`endif

endmodule

/* hdl/base64_codec.sv */
// Results of an accepted request pass through the job queue, the current-job register
//   and the output register, then leave one result per cycle while out_stall is low.
// Throughput: a request is taken every cycle while the four-job queue has room;
//   the output side drains one result a cycle while out_stall is low, so encoding is limited by the output side.
// Reset (rst, synchronous): direction returns to encode, the group and queue empty.
module base64_codec
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       bad_char
);

  logic fire, push, full, pop, q_valid;
  job_t push_job, q_job;

  assign in_stall = full;
  assign fire     = in_valid && !full;

  b64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fire           (fire),
    .in_data        (in_data),
    .in_last        (in_last),
    .push           (push),
    .job            (push_job)
  );

  b64_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (q_job)
  );

  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .out_last  (out_last),
    .bad_char  (bad_char)
  );

endmodule

/* dv/tb_base64_codec.sv */
module tb_base64_codec;
  import b64_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_PAUSE = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data;
  logic       out_last;
  logic       bad_char;

  base64_codec u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .out_last       (out_last),
    .bad_char       (bad_char)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // codec shadow state
  logic        dir_m    = DIR_ENCODE;
  logic [23:0] grp_buf  = 24'h0;
  logic [1:0]  grp_cnt  = 2'd0;
  logic        pad_flag = 1'b0;

  codec_req_t request_q[$];
  codec_out_t codec_out_q[$];

  int unsigned req_sent = 0;
  int unsigned req_acc = 0;
  int unsigned res_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 20;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;
  codec_req_t  cur_req;
  codec_out_t  exp_res;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v - 6'd26};
    if (v < 6'd62) return 8'h30 + {2'b00, v - 6'd52};
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic int sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic clear_group();
    grp_buf  = 24'h0;
    grp_cnt  = 2'd0;
    pad_flag = 1'b0;
  endtask

  task automatic push_out(input logic [7:0] d, input logic bad);
    codec_out_t r;
    r.data = d;
    r.last = 1'b0;
    r.bad  = bad;
    codec_out_q.push_back(r);
  endtask

  // emit the top n bytes of the gathered group
  task automatic emit_group_bytes(input int unsigned n);
    logic [23:0] t;
    for (int unsigned i = 0; i < n && i < 3; i++) begin
      t = grp_buf >> (16 - 8 * i);
      push_out(t[7:0], 1'b0);
    end
  endtask

  task automatic codec_step(input logic [7:0] d, input logic lst);
    int unsigned pos;
    int unsigned n0;
    int          v;
    logic [23:0] t;
    codec_out_t  r;
    n0  = codec_out_q.size();
    pos = 32'(grp_cnt);
    if (dir_m == DIR_ENCODE) begin
      if (pos > 2) pos = 2;
      grp_buf = grp_buf | ({16'h0, d} << (16 - 8 * pos));
      pos++;
      if (pos < 3 && !lst) begin
        grp_cnt = 2'(pos);
      end else begin
        for (int unsigned i = 0; i < 4; i++) begin
          t = grp_buf >> (18 - 6 * i);
          if (i < pos + 1) push_out(sextet_char(t[5:0]), 1'b0);
          else push_out(PAD_CHAR, 1'b0);
        end
        clear_group();
      end
    end else if (pad_flag) begin
      // swallow the rest of a padded group
      pos++;
      if (pos >= 4 || lst) clear_group();
      else grp_cnt = 2'(pos);
    end else if (d == PAD_CHAR) begin
      if (pos >= 2) emit_group_bytes(pos - 1);
      pos++;
      if (pos >= 4 || lst) begin
        clear_group();
      end else begin
        grp_cnt  = 2'(pos);
        pad_flag = 1'b1;
      end
    end else begin
      v = sextet_of(d);
      if (v < 0) begin
        push_out(8'h00, 1'b1);
        if (lst) begin
          if (pos >= 2) emit_group_bytes(pos - 1);
          clear_group();
        end
      end else begin
        grp_buf = grp_buf | (24'(v) << (18 - 6 * pos));
        pos++;
        if (pos >= 4) begin
          emit_group_bytes(3);
          clear_group();
        end else if (lst) begin
          if (pos >= 2) emit_group_bytes(pos - 1);
          clear_group();
        end else begin
          grp_cnt = 2'(pos);
        end
      end
    end
    if (codec_out_q.size() > n0) begin
      r = codec_out_q.pop_back();
      r.last = 1'b1;
      codec_out_q.push_back(r);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_acc == req_sent) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        in_gap   <= $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req  = request_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= cur_req.data;
        in_last  <= cur_req.last;
        req_sent <= req_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        codec_step(in_data, in_last);
        req_acc <= req_acc + 1;
      end
      if (out_valid && !out_stall) begin
        res_seen++;
        if (codec_out_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result data=%02h last=%0b bad=%0b",
                                  out_data, out_last, bad_char));
        end else begin
          exp_res = codec_out_q.pop_front();
          if (out_data !== exp_res.data || out_last !== exp_res.last ||
              bad_char !== exp_res.bad) begin
            flag_mismatch($sformatf("result %0d: got data=%02h last=%0b bad=%0b, want %02h %0b %0b",
                                    res_seen, out_data, out_last, bad_char,
                                    exp_res.data, exp_res.last, exp_res.bad));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               quiet_cycles, codec_out_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic [7:0] d, input logic lst);
    codec_req_t r;
    r.data = d;
    r.last = lst;
    request_q.push_back(r);
  endtask

  task automatic wait_drain();
    while (request_q.size() != 0 || in_valid || codec_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_direction(input logic v);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    dir_m = v;
    clear_group();
    cfg_writes++;
  endtask

  // well-formed text of random bytes, now and then broken
  task automatic queue_b64_message(input int nbytes, output int nchars);
    logic [7:0]  raw[$];
    logic [7:0]  txt[$];
    logic [23:0] g;
    logic        pad;
    int          k;
    for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom_range(0, 255)));
    raw.push_back(8'h00);
    raw.push_back(8'h00);
    pad = ($urandom_range(0, 3) != 0);
    for (int s = 0; s < nbytes; s += 3) begin
      k = (nbytes - s < 3) ? nbytes - s : 3;
      g = {raw[s], raw[s+1], raw[s+2]};
      for (int j = 0; j <= k; j++) txt.push_back(sextet_char(6'(g >> (18 - 6 * j))));
      if (pad) for (int j = k + 1; j < 4; j++) txt.push_back(PAD_CHAR);
    end
    case ($urandom_range(0, 7))
      0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      1: if (txt.size() > 1) void'(txt.pop_back());
      2: if (txt[txt.size() - 1] == PAD_CHAR)
           txt[txt.size() - 1] = sextet_char(6'($urandom_range(0, 63)));
      default: ;
    endcase
    nchars = txt.size();
    for (int i = 0; i < nchars; i++) queue_req(txt[i], i == nchars - 1);
  endtask

  task automatic run_random_phase(input logic dir, input int n_req);
    int cnt;
    int len;
    idle_pct = $urandom_range(0, 35);
    write_direction(dir);
    cnt = 0;
    while (cnt < n_req) begin
      if (dir == DIR_ENCODE) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) queue_req(8'($urandom_range(0, 255)), i == len - 1);
        cnt += len;
      end else if ($urandom_range(0, 7) == 0) begin
        queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        queue_b64_message($urandom_range(1, 9), len);
        cnt += len;
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_direction(DIR_ENCODE);
    // full group, then one- and two-byte tails
    queue_req(8'h4D, 1'b0);
    queue_req(8'h61, 1'b0);
    queue_req(8'h6E, 1'b0);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFE, 1'b1);
    wait_drain();

    write_direction(DIR_DECODE);
    queue_req("T", 1'b0);
    queue_req("Q", 1'b0);
    queue_req(PAD_CHAR, 1'b0);
    queue_req(PAD_CHAR, 1'b0);
    // pad at position one, then a character ignored with the end flag on it
    queue_req("A", 1'b0);
    queue_req(PAD_CHAR, 1'b0);
    queue_req("x", 1'b1);
    queue_req(PAD_CHAR, 1'b1);
    // bad character inside a group, then a pad carrying the end flag
    queue_req("T", 1'b0);
    queue_req(8'h00, 1'b0);
    queue_req("Q", 1'b0);
    queue_req(PAD_CHAR, 1'b1);
    // bad character that ends the message
    queue_req("T", 1'b0);
    queue_req("W", 1'b0);
    queue_req(8'hFF, 1'b1);
    // lone tail character
    queue_req("Q", 1'b1);
    wait_drain();

    run_random_phase(DIR_ENCODE, 90);
    run_random_phase(DIR_DECODE, 95);
    run_random_phase(DIR_ENCODE, 70);
    calm = 1'b1;
    run_random_phase(DIR_DECODE, 100);

    $display("Covered %0d requests and %0d results across %0d direction writes, %0d mismatches",
             req_acc, res_seen, cfg_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
